// File: hw/rtl/lrukv_pkg.sv
// shared types and constants for the lru key/value cache
package lrukv_pkg;

	// fixed widths of the channel fields and the capacity register
	localparam int KEY_W = 32;
	localparam int DATA_W = 32;
	localparam int CAP_W = 5;

	// capacity after reset
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	// request kind
	typedef enum logic {
		MODE_GET = 1'b0,
		MODE_PUT = 1'b1
	} mode_t;

	// one request word as held in the input stage
	typedef struct packed {
		mode_t              mode;
		logic [KEY_W-1:0]   lookup_key;
		logic [DATA_W-1:0]  write_value;
	} req_t;

	// one response word as produced by the entry store
	typedef struct packed {
		logic               hit;
		logic [DATA_W-1:0]  read_value;
	} rsp_t;

endpackage

// File: hw/rtl/lrukv_ifs.sv
// valid/ready channel interfaces for requests and responses

interface lrukv_req_if;
	logic                              valid;
	logic                              ready;
	logic                              mode;
	logic signed [lrukv_pkg::KEY_W-1:0]  lookup_key;
	logic signed [lrukv_pkg::DATA_W-1:0] write_value;

	modport source (output valid, output mode, output lookup_key, output write_value,
		input ready);
	modport sink (input valid, input mode, input lookup_key, input write_value,
		output ready);
endinterface

interface lrukv_rsp_if;
	logic                              valid;
	logic                              ready;
	logic                              hit;
	logic signed [lrukv_pkg::DATA_W-1:0] read_value;

	modport source (output valid, output hit, output read_value, input ready);
	modport sink (input valid, input hit, input read_value, output ready);
endinterface

// File: hw/rtl/lru_key_value_cache_top.sv
// top level of the fully associative lru key/value cache
//
//  channel | dir | payload                          | handshake
//  req     | in  | mode, lookup_key, write_value    | valid/ready
//  rsp     | out | hit, read_value                  | valid/ready
//  cfg     | in  | cfg_wr_data (capacity)           | cfg_wr_en
//
// one word per cycle sustained while rsp is not stalled; an accepted request passes the input stage
// register and then the response register, around the combinational lookup and the registered
// update of all entries.
// reset empties the cache and sets the capacity to sixteen; no clearing pass.
// a stalled response holds the input stage, which still takes a word while it is empty.
module lru_key_value_cache_top #(
	parameter int ENTRIES = 16,
	parameter int KEY_BITS = 32,
	parameter int DATA_BITS = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	lrukv_req_if.sink                    req,
	lrukv_rsp_if.source                  rsp,
	input  logic                         cfg_wr_en,
	input  logic [lrukv_pkg::CAP_W-1:0]  cfg_wr_data
);

	localparam int CW = $clog2(ENTRIES + 1);

	logic                         valid_s1;
	lrukv_pkg::req_t              req_s1;
	logic                         rsp_valid_q;
	lrukv_pkg::rsp_t              rsp_q;
	logic [lrukv_pkg::CAP_W-1:0]  cap_q;
	logic                         advance;
	lrukv_pkg::rsp_t              st_rsp;
	logic [CW-1:0]                occ_count;

	// stage moves when the response register is free or being drained
	assign advance = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || advance;

	// capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= lrukv_pkg::CAP_RESET;
		end else if (cfg_wr_en) begin
			cap_q <= cfg_wr_data;
		end
	end

	// input stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	// input stage payload
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_s1.mode <= lrukv_pkg::mode_t'(req.mode);
			req_s1.lookup_key <= req.lookup_key;
			req_s1.write_value <= req.write_value;
		end
	end

	lrukv_store #(
		.ENTRIES   (ENTRIES),
		.KEY_BITS  (KEY_BITS),
		.DATA_BITS (DATA_BITS)
	) u_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.upd       (advance),
		.req       (req_s1),
		.cap       (cap_q),
		.rsp       (st_rsp),
		.occ_count (occ_count)
	);

	// response register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// response register payload
	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q <= st_rsp;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.hit = rsp_q.hit;
	assign rsp.read_value = rsp_q.read_value;

	// a response only appears after the stage moved a word
	a_rsp_from_stage: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(advance))
		else $error("response valid without a processed request");

	// occupancy never exceeds the entry count
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_count <= CW'(ENTRIES))
		else $error("occupancy above entry count");

	// a get never changes occupancy
	a_get_keeps_count: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && (req_s1.mode == lrukv_pkg::MODE_GET)) |=> $stable(occ_count))
		else $error("get changed occupancy");

	// nonzero read data only comes with a hit
	a_data_needs_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && (rsp_q.read_value != '0)) |-> rsp_q.hit)
		else $error("read data on a miss");

endmodule

// File: hw/rtl/lrukv_store.sv
// entry store: parallel key match, age ranks, victim and free slot choice, update
module lrukv_store #(
	parameter int ENTRIES = 16,
	parameter int KEY_BITS = 32,
	parameter int DATA_BITS = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             upd,
	input  lrukv_pkg::req_t                  req,
	input  logic [lrukv_pkg::CAP_W-1:0]      cap,
	output lrukv_pkg::rsp_t                  rsp,
	output logic [$clog2(ENTRIES+1)-1:0]     occ_count
);

	localparam int KW = (KEY_BITS < lrukv_pkg::KEY_W) ? KEY_BITS : lrukv_pkg::KEY_W;
	localparam int DW = (DATA_BITS < lrukv_pkg::DATA_W) ? DATA_BITS : lrukv_pkg::DATA_W;
	localparam int AW = $clog2(ENTRIES);
	localparam int CW = $clog2(ENTRIES + 1);
	localparam int MW = (CW > lrukv_pkg::CAP_W) ? CW : lrukv_pkg::CAP_W;
	localparam logic [AW-1:0] AGE_MAX = AW'(ENTRIES - 1);

	logic [ENTRIES-1:0]  valid_q;
	logic [CW-1:0]       count_q;
	logic [KW-1:0]       key_q  [ENTRIES];
	logic [DW-1:0]       data_q [ENTRIES];
	logic [AW-1:0]       age_q  [ENTRIES];

	logic [KW-1:0]       key;
	logic [ENTRIES-1:0]  match;
	logic [ENTRIES-1:0]  victim_oh;
	logic [ENTRIES-1:0]  free_oh;
	logic [ENTRIES-1:0]  tgt_oh;
	logic [AW-1:0]       hit_age;
	logic [AW-1:0]       oldest_age;
	logic [AW-1:0]       ref_age;
	logic [DW-1:0]       hit_data;
	logic [MW-1:0]       eff_cap;
	logic                hit;
	logic                is_put;
	logic                full;
	logic                do_touch;
	logic                do_insert;

	assign key = req.lookup_key[KW-1:0];
	assign is_put = (req.mode == lrukv_pkg::MODE_PUT);

	// key compare against every entry
	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			match[i] = valid_q[i] && (key_q[i] == key);
		end
	end
	assign hit = |match;

	// age and data of the matching entry (keys are unique, so an or-reduce selects)
	always_comb begin
		hit_age = '0;
		hit_data = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (match[i]) begin
				hit_age = hit_age | age_q[i];
				hit_data = hit_data | data_q[i];
			end
		end
	end

	// effective capacity: zero acts as one, clamped to the entry count
	always_comb begin
		eff_cap = MW'(cap);
		if (cap == '0) begin
			eff_cap = MW'(1);
		end
		if (eff_cap > MW'(ENTRIES)) begin
			eff_cap = MW'(ENTRIES);
		end
	end
	assign full = (MW'(count_q) >= eff_cap);

	// ages of valid entries form 0..count-1, so the oldest holds count-1
	assign oldest_age = AW'(count_q - CW'(1));
	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			victim_oh[i] = valid_q[i] && (age_q[i] == oldest_age);
		end
	end

	// lowest free entry
	assign free_oh = ~valid_q & (valid_q + ENTRIES'(1));

	// pick the entry this request writes
	always_comb begin
		tgt_oh = '0;
		ref_age = hit_age;
		if (hit) begin
			tgt_oh = match;
		end else if (is_put) begin
			if (full) begin
				tgt_oh = victim_oh;
				ref_age = oldest_age;
			end else begin
				tgt_oh = free_oh;
			end
		end
	end
	assign do_touch = hit || (is_put && full);
	assign do_insert = is_put && !hit && !full;

	// response: data only on a get hit
	assign rsp.hit = hit;
	assign rsp.read_value = (hit && !is_put) ? lrukv_pkg::DATA_W'(hit_data) : '0;
	assign occ_count = count_q;

	// valid bits and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			count_q <= '0;
		end else if (upd && do_insert) begin
			valid_q <= valid_q | tgt_oh;
			count_q <= count_q + CW'(1);
		end
	end

	// key, data and age ranks
	always_ff @(posedge clk) begin
		if (upd) begin
			for (int i = 0; i < ENTRIES; i++) begin
				if (tgt_oh[i]) begin
					age_q[i] <= '0;
					if (is_put) begin
						key_q[i] <= key;
						data_q[i] <= req.write_value[DW-1:0];
					end
				end else if (valid_q[i]) begin
					if (do_insert && (age_q[i] < AGE_MAX)) begin
						age_q[i] <= age_q[i] + AW'(1);
					end else if (do_touch && (age_q[i] < ref_age)) begin
						age_q[i] <= age_q[i] + AW'(1);
					end
				end
			end
		end
	end

endmodule
